// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file tcphs_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/tcphs_pkg.sv =====
// ----------------------------------------------------------------------------
// tcphs_pkg
// Types and codes for the TCP three-way handshake engine.
// ----------------------------------------------------------------------------
package tcphs_pkg;

  typedef enum logic [2:0] {
    ST_CLOSED   = 3'd0,
    ST_LISTEN   = 3'd1,
    ST_SYN_SENT = 3'd2,
    ST_SYN_RECV = 3'd3,
    ST_ESTAB    = 3'd4
  } conn_state_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ESTAB = 2'd1,
    EV_FAIL  = 2'd2,
    EV_DATA  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_SEGMENT = 2'd1,
    MODE_ACTIVE  = 2'd2,
    MODE_PASSIVE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_INITIAL_RTO = 2'd0,
    CFG_MAX_RTO     = 2'd1,
    CFG_MAX_RETRIES = 2'd2,
    CFG_LOCAL_PORT  = 2'd3
  } cfg_index_t;

  // Decoded action for the item in the input register.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_TICK_CLR,
    ACT_TICK_INC,
    ACT_TIMEOUT_FAIL,
    ACT_RETX,
    ACT_ACTIVE_OPEN,
    ACT_PASSIVE_OPEN,
    ACT_DUP_SYN,
    ACT_SYNACK_RX,
    ACT_DUP_SYNACK,
    ACT_LISTEN_SYN,
    ACT_ACK_RX,
    ACT_DATA
  } action_t;

  localparam int unsigned IN_TDATA_W  = 136;
  localparam int unsigned OUT_TDATA_W = 104;

  localparam logic [15:0] RST_INITIAL_RTO = 16'd1000;
  localparam logic [15:0] RST_MAX_RTO     = 16'd8000;
  localparam logic [3:0]  RST_MAX_RETRIES = 4'd5;

endpackage

// ===== rtl/tcp_handshake_fsm.sv =====
// ----------------------------------------------------------------------------
// tcp_handshake_fsm
// Single-connection TCP three-way handshake engine.
// ----------------------------------------------------------------------------
// Every input transaction (a 1 ms tick, a received segment header, an active
// open or a passive open) yields exactly one output transaction carrying an
// optional control segment to send, the connection state after the item and
// an event code. An item is taken into an input register, decoded and applied
// to the connection state by one level of compare/add logic, and lands in an
// output register that drives out_tvalid, and one item per cycle is
// sustained as long as out_tready is high. The output register
// alone sets the rate: a stalled output holds the input register, and
// in_tready drops only while both are full. Configuration writes are taken at
// any time (cfg_ready is tied high) and should be issued only while the engine
// is idle; a new initial_rto takes effect at the next open.
// ----------------------------------------------------------------------------
module tcp_handshake_fsm #(
  parameter int unsigned CFG_IDX_W = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata, low bit up: syn_bit, ack_bit, pkt_seq[31:0], pkt_ack[31:0],
  // peer_port[15:0], payload_len[15:0], new_isn[31:0], zero pad [135:130]
  input  logic [tcphs_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: mode[1:0]
  input  logic [1:0]                           in_tuser,
  // Result channel.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata, low bit up: send_valid, send_syn, send_ackflag, send_seq[31:0],
  // send_acknum[31:0], send_dst_port[15:0], conn_state[2:0], data_len[15:0],
  // zero pad [103:102]
  output logic [tcphs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // tuser: event_res[1:0]
  output logic [1:0]                           out_tuser,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [15:0]                          cfg_data
);

  // ---------------------------------------------------------------- config
  logic [15:0] initial_rto_r;
  logic [15:0] max_rto_r;
  logic [3:0]  max_retries_r;
  logic [15:0] local_port_r;   // stored but not read anywhere in the engine

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_rto_r <= tcphs_pkg::RST_INITIAL_RTO;
      max_rto_r     <= tcphs_pkg::RST_MAX_RTO;
      max_retries_r <= tcphs_pkg::RST_MAX_RETRIES;
      local_port_r  <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_W'(tcphs_pkg::CFG_INITIAL_RTO)) initial_rto_r <= cfg_data;
      if (cfg_index == CFG_IDX_W'(tcphs_pkg::CFG_MAX_RTO))     max_rto_r     <= cfg_data;
      if (cfg_index == CFG_IDX_W'(tcphs_pkg::CFG_MAX_RETRIES)) max_retries_r <= cfg_data[3:0];
      if (cfg_index == CFG_IDX_W'(tcphs_pkg::CFG_LOCAL_PORT))  local_port_r  <= cfg_data;
    end
  end

  // --------------------------------------------------------- input register
  logic                   in_v_r;
  tcphs_pkg::mode_t       mode_r;
  logic                   syn_r;
  logic                   ack_r;
  logic [31:0]            pkt_seq_r;
  logic [31:0]            pkt_ack_r;
  logic [15:0]            peer_port_r;
  logic [15:0]            payload_len_r;
  logic [31:0]            new_isn_r;

  logic                   out_v_r;
  logic                   proc;   // item in the input register is applied now

  assign proc      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      mode_r        <= tcphs_pkg::mode_t'(in_tuser);
      syn_r         <= in_tdata[0];
      ack_r         <= in_tdata[1];
      pkt_seq_r     <= in_tdata[33:2];
      pkt_ack_r     <= in_tdata[65:34];
      peer_port_r   <= in_tdata[81:66];
      payload_len_r <= in_tdata[97:82];
      new_isn_r     <= in_tdata[129:98];
    end
  end

  // ------------------------------------------------------ connection state
  tcphs_pkg::conn_state_t state_r, state_nxt;
  logic [31:0] our_isn_r,   our_isn_nxt;
  logic [31:0] their_isn_r, their_isn_nxt;
  logic [31:0] snd_nxt_r,   snd_nxt_nxt;
  logic [31:0] rcv_nxt_r,   rcv_nxt_nxt;
  logic [15:0] rport_r,     rport_nxt;
  logic [15:0] rto_r,       rto_nxt;
  logic [3:0]  retry_r,     retry_nxt;
  logic [15:0] tick_r,      tick_nxt;

  // ---------------------------------------------------------------- decode
  tcphs_pkg::action_t act;
  logic [15:0] tick_inc;
  logic        timer_fire;
  logic        in_handshake;
  logic        ack_ok;       // ack number matches our next sequence number

  assign tick_inc     = tick_r + 16'd1;
  assign timer_fire   = (tick_inc >= rto_r);
  assign in_handshake = (state_r == tcphs_pkg::ST_SYN_SENT) ||
                        (state_r == tcphs_pkg::ST_SYN_RECV);
  assign ack_ok       = (pkt_ack_r == snd_nxt_r);

  // Segment rules are checked in a fixed order; the first match wins.
  always_comb begin
    act = tcphs_pkg::ACT_NONE;
    unique case (mode_r)
      tcphs_pkg::MODE_TICK: begin
        if (!in_handshake)                       act = tcphs_pkg::ACT_TICK_CLR;
        else if (!timer_fire)                    act = tcphs_pkg::ACT_TICK_INC;
        else if (retry_r >= max_retries_r)       act = tcphs_pkg::ACT_TIMEOUT_FAIL;
        else                                     act = tcphs_pkg::ACT_RETX;
      end
      tcphs_pkg::MODE_ACTIVE:  act = tcphs_pkg::ACT_ACTIVE_OPEN;
      tcphs_pkg::MODE_PASSIVE: act = tcphs_pkg::ACT_PASSIVE_OPEN;
      tcphs_pkg::MODE_SEGMENT: begin
        priority if (state_r == tcphs_pkg::ST_SYN_RECV && syn_r &&
                     pkt_seq_r == their_isn_r)
          act = tcphs_pkg::ACT_DUP_SYN;
        else if (state_r == tcphs_pkg::ST_SYN_SENT && syn_r && ack_r && ack_ok)
          act = tcphs_pkg::ACT_SYNACK_RX;
        else if (state_r == tcphs_pkg::ST_ESTAB && syn_r && ack_r && ack_ok &&
                 pkt_seq_r == their_isn_r)
          act = tcphs_pkg::ACT_DUP_SYNACK;
        else if (state_r == tcphs_pkg::ST_LISTEN && syn_r)
          act = tcphs_pkg::ACT_LISTEN_SYN;
        else if (state_r == tcphs_pkg::ST_SYN_RECV && ack_r && ack_ok &&
                 pkt_seq_r == rcv_nxt_r)
          act = tcphs_pkg::ACT_ACK_RX;
        else if (state_r == tcphs_pkg::ST_ESTAB && payload_len_r != 16'd0)
          act = tcphs_pkg::ACT_DATA;
        else
          act = tcphs_pkg::ACT_NONE;
      end
      default: act = tcphs_pkg::ACT_NONE;
    endcase
  end

  // ---------------------------------------------------------- next state
  always_comb begin
    state_nxt     = state_r;
    our_isn_nxt   = our_isn_r;
    their_isn_nxt = their_isn_r;
    snd_nxt_nxt   = snd_nxt_r;
    rcv_nxt_nxt   = rcv_nxt_r;
    rport_nxt     = rport_r;
    rto_nxt       = rto_r;
    retry_nxt     = retry_r;
    tick_nxt      = tick_r;
    unique case (act)
      tcphs_pkg::ACT_TICK_CLR: tick_nxt = 16'd0;
      tcphs_pkg::ACT_TICK_INC: tick_nxt = tick_inc;
      tcphs_pkg::ACT_TIMEOUT_FAIL: begin
        tick_nxt  = 16'd0;
        state_nxt = tcphs_pkg::ST_CLOSED;
      end
      tcphs_pkg::ACT_RETX: begin
        tick_nxt  = 16'd0;
        retry_nxt = retry_r + 4'd1;
        // Doubling stays below max_rto, so it never overflows 16 bits.
        if (rto_r < (max_rto_r >> 1)) rto_nxt = {rto_r[14:0], 1'b0};
        else                          rto_nxt = max_rto_r;
      end
      tcphs_pkg::ACT_ACTIVE_OPEN: begin
        rport_nxt   = peer_port_r;
        our_isn_nxt = new_isn_r;
        snd_nxt_nxt = new_isn_r + 32'd1;
        state_nxt   = tcphs_pkg::ST_SYN_SENT;
        rto_nxt     = initial_rto_r;
        retry_nxt   = 4'd0;
        tick_nxt    = 16'd0;
      end
      tcphs_pkg::ACT_PASSIVE_OPEN: begin
        state_nxt = tcphs_pkg::ST_LISTEN;
        rto_nxt   = initial_rto_r;
        retry_nxt = 4'd0;
        tick_nxt  = 16'd0;
      end
      tcphs_pkg::ACT_SYNACK_RX: begin
        their_isn_nxt = pkt_seq_r;
        rcv_nxt_nxt   = pkt_seq_r + 32'd1;
        state_nxt     = tcphs_pkg::ST_ESTAB;
        tick_nxt      = 16'd0;
      end
      tcphs_pkg::ACT_LISTEN_SYN: begin
        rport_nxt     = peer_port_r;
        their_isn_nxt = pkt_seq_r;
        rcv_nxt_nxt   = pkt_seq_r + 32'd1;
        our_isn_nxt   = new_isn_r;
        snd_nxt_nxt   = new_isn_r + 32'd1;
        state_nxt     = tcphs_pkg::ST_SYN_RECV;
        rto_nxt       = initial_rto_r;
        retry_nxt     = 4'd0;
        tick_nxt      = 16'd0;
      end
      tcphs_pkg::ACT_ACK_RX: begin
        state_nxt = tcphs_pkg::ST_ESTAB;
        tick_nxt  = 16'd0;
      end
      default: ;  // no state change
    endcase
  end

  // --------------------------------------------------------------- outputs
  logic        snd_v, snd_syn, snd_ack;
  logic [31:0] snd_seq, snd_acknum;
  tcphs_pkg::event_t ev;
  logic [15:0] dlen;

  always_comb begin
    snd_v      = 1'b0;
    snd_syn    = 1'b0;
    snd_ack    = 1'b0;
    snd_seq    = 32'd0;
    snd_acknum = 32'd0;
    ev         = tcphs_pkg::EV_NONE;
    dlen       = 16'd0;
    unique case (act)
      tcphs_pkg::ACT_TIMEOUT_FAIL: ev = tcphs_pkg::EV_FAIL;
      tcphs_pkg::ACT_RETX: begin
        snd_v   = 1'b1;
        snd_syn = 1'b1;
        snd_seq = our_isn_r;
        if (state_r == tcphs_pkg::ST_SYN_RECV) begin
          snd_ack    = 1'b1;
          snd_acknum = rcv_nxt_r;
        end
      end
      tcphs_pkg::ACT_ACTIVE_OPEN: begin
        snd_v   = 1'b1;
        snd_syn = 1'b1;
        snd_seq = new_isn_r;
      end
      tcphs_pkg::ACT_DUP_SYN, tcphs_pkg::ACT_LISTEN_SYN: begin
        snd_v      = 1'b1;
        snd_syn    = 1'b1;
        snd_ack    = 1'b1;
        snd_seq    = our_isn_nxt;
        snd_acknum = rcv_nxt_nxt;
      end
      tcphs_pkg::ACT_SYNACK_RX: begin
        snd_v      = 1'b1;
        snd_ack    = 1'b1;
        snd_seq    = snd_nxt_r;
        snd_acknum = rcv_nxt_nxt;
        ev         = tcphs_pkg::EV_ESTAB;
      end
      tcphs_pkg::ACT_DUP_SYNACK: begin
        snd_v      = 1'b1;
        snd_ack    = 1'b1;
        snd_seq    = snd_nxt_r;
        snd_acknum = rcv_nxt_r;
      end
      tcphs_pkg::ACT_ACK_RX: ev = tcphs_pkg::EV_ESTAB;
      tcphs_pkg::ACT_DATA: begin
        ev   = tcphs_pkg::EV_DATA;
        dlen = payload_len_r;
      end
      default: ;  // nothing sent, no event
    endcase
  end

  // ------------------------------------------------------ state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcphs_pkg::ST_CLOSED;
      our_isn_r   <= 32'd0;
      their_isn_r <= 32'd0;
      snd_nxt_r   <= 32'd0;
      rcv_nxt_r   <= 32'd0;
      rport_r     <= 16'd0;
      rto_r       <= tcphs_pkg::RST_INITIAL_RTO;
      retry_r     <= 4'd0;
      tick_r      <= 16'd0;
    end else if (proc) begin
      state_r     <= state_nxt;
      our_isn_r   <= our_isn_nxt;
      their_isn_r <= their_isn_nxt;
      snd_nxt_r   <= snd_nxt_nxt;
      rcv_nxt_r   <= rcv_nxt_nxt;
      rport_r     <= rport_nxt;
      rto_r       <= rto_nxt;
      retry_r     <= retry_nxt;
      tick_r      <= tick_nxt;
    end
  end

  // ------------------------------------------------------- output register
  logic [tcphs_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [1:0]                        out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= proc;
    end
  end

  // Destination port follows the (possibly just updated) peer port, and is
  // zero whenever no segment goes out.
  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= {2'b00, dlen, 3'(state_nxt),
                     (snd_v ? rport_nxt : 16'd0),
                     snd_acknum, snd_seq, snd_ack, snd_syn, snd_v};
      out_user_r <= 2'(ev);
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/tcphs_checker.sv =====
// ----------------------------------------------------------------------------
// tcphs_checker
// Port-level checks for the TCP handshake engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcphs_checker #(
  parameter int unsigned CFG_IDX_W = 2
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [tcphs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic [1:0]                        in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tcphs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [1:0]                        out_tuser,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [CFG_IDX_W-1:0]              cfg_index,
  input logic [15:0]                       cfg_data
);

  logic out_xfer;
  assign out_xfer = out_tvalid && out_tready;

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // No segment means all segment fields read zero.
  `ASSERT_IMPLY(a_no_send_zero, clk, rst_n, out_xfer && !out_tdata[0], out_tdata[82:1] == 82'd0)

  // Payload length is reported only with the data event.
  `ASSERT_IMPLY(a_dlen_zero, clk, rst_n, out_xfer && out_tuser != 2'(tcphs_pkg::EV_DATA), out_tdata[101:86] == 16'd0)

  // Becoming established is reported with the established state.
  `ASSERT_IMPLY(a_estab_state, clk, rst_n, out_xfer && out_tuser == 2'(tcphs_pkg::EV_ESTAB), out_tdata[85:83] == 3'(tcphs_pkg::ST_ESTAB))

  // A failed handshake closes the link and sends nothing.
  `ASSERT_IMPLY(a_fail_closed, clk, rst_n, out_xfer && out_tuser == 2'(tcphs_pkg::EV_FAIL), out_tdata[85:83] == 3'(tcphs_pkg::ST_CLOSED) && !out_tdata[0])

endmodule

bind tcp_handshake_fsm tcphs_checker #(.CFG_IDX_W(CFG_IDX_W)) u_tcphs_checker (.*);
